### design/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants of the token scanner
// Token kinds, scanner modes, transaction payloads and the keyword table.
// ----------------------------------------------------------------------------
`default_nettype none

package cst_pkg;

  typedef enum logic [5:0] {
    K_INT,
    K_VOID,
    K_IF,
    K_ELSE,
    K_WHILE,
    K_BREAK,
    K_CONTINUE,
    K_RETURN,
    K_IDENT,
    K_CONST,
    K_PLUS,
    K_MINUS,
    K_MUL,
    K_DIV,
    K_MOD,
    K_ASSIGN,
    K_EQ,
    K_NE,
    K_LT,
    K_LE,
    K_GT,
    K_GE,
    K_AND,
    K_OR,
    K_NOT,
    K_LPAREN,
    K_RPAREN,
    K_LBRACE,
    K_RBRACE,
    K_SEMI,
    K_COMMA,
    K_EOF,
    K_UNKNOWN
  } token_kind_e;

  typedef enum logic [2:0] {
    M_IDLE,
    M_IDENT,
    M_NUMBER,
    M_HELD,
    M_SLASH,
    M_LINE,
    M_BLOCK,
    M_BLOCK_STAR
  } scan_mode_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    token_kind_e token_kind;
    logic [23:0] token_number;
    logic [15:0] start_line;
    logic [23:0] start_offset;
    logic [15:0] token_length;
    logic        last_of_run;
  } out_token_t;

  localparam int NumKeywords = 8;

  // keyword spellings, right aligned and zero padded
  localparam logic [63:0] KW_TEXT [NumKeywords] = '{
    "int", "void", "if", "else", "while", "break", "continue", "return"
  };

  localparam logic [3:0] KW_LEN [NumKeywords] = '{
    4'd3, 4'd4, 4'd2, 4'd4, 4'd5, 4'd5, 4'd8, 4'd6
  };

  // character at position pos of keyword idx (valid for pos below its length)
  function automatic logic [7:0] kw_char(input logic [2:0] idx, input logic [2:0] pos);
    logic [63:0] t;
    t = KW_TEXT[idx] << (8 * (4'd8 - KW_LEN[idx]));
    return t[63 - 8 * pos -: 8];
  endfunction

endpackage

`default_nettype wire

### design/cst_keyword_match.sv
// ----------------------------------------------------------------------------
// cst_keyword_match: keyword candidate filter
// Narrows the keyword candidate set by one character and resolves the kind
// of a finished word.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_keyword_match #(
  parameter int LENGTH_BITS = 16
) (
  input  logic [7:0]             cand_i,
  input  logic [LENGTH_BITS-1:0] index_i,
  input  logic [7:0]             char_i,
  input  logic [7:0]             final_cand_i,
  input  logic [LENGTH_BITS-1:0] final_len_i,
  output logic [7:0]             cand_o,
  output cst_pkg::token_kind_e   kind_o
);

  always_comb begin
    for (int i = 0; i < cst_pkg::NumKeywords; i++) begin
      cand_o[i] = cand_i[i]
                  && (index_i < LENGTH_BITS'(cst_pkg::KW_LEN[i]))
                  && (cst_pkg::kw_char(3'(i), index_i[2:0]) == char_i);
    end
  end

  // a surviving candidate whose length matches turns the word into a keyword
  always_comb begin
    kind_o = cst_pkg::K_IDENT;
    for (int i = 0; i < cst_pkg::NumKeywords; i++) begin
      if (final_cand_i[i] && (final_len_i == LENGTH_BITS'(cst_pkg::KW_LEN[i]))) begin
        kind_o = cst_pkg::token_kind_e'(6'(i));
      end
    end
  end

endmodule

`default_nettype wire

### design/cst_out_queue.sv
// ----------------------------------------------------------------------------
// cst_out_queue: result queue
// Four-entry queue that takes up to two tokens per cycle and hands out one unless the output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_out_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_a_i,
  input  cst_pkg::out_token_t data_a_i,
  input  logic                push_b_i,
  input  cst_pkg::out_token_t data_b_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cst_pkg::out_token_t out_data_o,
  output logic [2:0]          count_o
);

  cst_pkg::out_token_t mem_q [4];
  logic [1:0] wr_q, wr_d, rd_q, rd_d, wr_b;
  logic [2:0] count_q, count_d;
  logic       pop;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (count_q != 3'd0);
  assign out_data_o  = mem_q[rd_q];
  assign room_o      = (count_q <= 3'd2);
  assign count_o     = count_q;
  assign wr_b        = wr_q + {1'b0, push_a_i};

  always_comb begin
    wr_d    = wr_q + {1'b0, push_a_i} + {1'b0, push_b_i};
    rd_d    = rd_q + {1'b0, pop};
    count_d = count_q + {2'b0, push_a_i} + {2'b0, push_b_i} - {2'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 2'd0;
      rd_q    <= 2'd0;
      count_q <= 3'd0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_a_i) begin
      mem_q[wr_q] <= data_a_i;
    end
    if (push_b_i) begin
      mem_q[wr_b] <= data_b_i;
    end
  end

endmodule

`default_nettype wire

### design/c_subset_token_scanner.sv
// ----------------------------------------------------------------------------
// c_subset_token_scanner: streaming token scanner for a small C subset
// One source byte per transaction in, tokens out as they complete.
// ----------------------------------------------------------------------------
//
//   channel   direction  payload       handshake
//   in        input      in_item_t     in_valid_i / in_stall_o
//   out       output     out_token_t   out_valid_o / out_stall_i
//
// one byte is taken per cycle unless the input stalls; it is held in the
// input register, where the scan logic and the keyword filter decide its
// tokens in a single pass
// up to two tokens go into a four-entry result queue; input stalls when the
// queue has fewer than two free entries
// reset clears the scanner to idle, line one, position and token index zero
// an end-of-text transaction flushes, emits end-of-file and restarts the scan
//
`default_nettype none

module c_subset_token_scanner #(
  parameter int POSITION_BITS = 24,
  parameter int LINE_BITS     = 16,
  parameter int LENGTH_BITS   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cst_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cst_pkg::out_token_t out_data_o
);

  // input register
  logic              in_valid_q, in_valid_d;
  cst_pkg::in_item_t in_data_q;
  logic              room, fire, in_take;

  // scanner state
  cst_pkg::scan_mode_e    mode_q, mode_d;
  logic [7:0]             held_q, held_d;
  logic [7:0]             cand_q, cand_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [23:0]            tokno_q, tokno_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] poff_q, poff_d;
  logic [LINE_BITS-1:0]   pline_q, pline_d;
  logic [LENGTH_BITS-1:0] plen_q, plen_d;

  logic [7:0] c;
  logic       eot;
  logic       is_digit, is_alpha, is_alnum, is_ws, is_held_char;
  logic       pend, cont, again, pair_hit;
  logic       a_v, b_v;
  cst_pkg::token_kind_e pair_kind, held_kind, single_kind, word_kind, a_kind, b_kind;
  cst_pkg::out_token_t  tok_a, tok_b;
  logic [7:0]             kw_cand_in, kw_cand_out;
  logic [LENGTH_BITS-1:0] kw_index;
  logic [23:0]            tokno_inc1, tokno_inc2;
  logic [2:0]             queue_count;

  // counters zero extended, then cut to the field widths
  logic [LINE_BITS+15:0]     line_ext, pline_ext;
  logic [POSITION_BITS+23:0] pos_ext, poff_ext;
  logic [LENGTH_BITS+15:0]   plen_ext;

  assign line_ext  = {16'b0, line_q};
  assign pline_ext = {16'b0, pline_q};
  assign pos_ext   = {24'b0, pos_q};
  assign poff_ext  = {24'b0, poff_q};
  assign plen_ext  = {16'b0, plen_q};

  // ---------------------------------------------------------------- input side
  assign fire       = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= in_data_i;
    end
  end

  // ---------------------------------------------------------- character decode
  assign c   = in_data_q.char_code;
  assign eot = in_data_q.end_of_text;

  assign is_digit = (c >= "0") && (c <= "9");
  assign is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  assign is_alnum = is_digit || is_alpha;
  assign is_ws    = (c == 8'h20) || (c == 8'h09) || (c == 8'h0a) || (c == 8'h0d)
                    || (c == 8'h0c) || (c == 8'h0b);
  assign is_held_char = (c == "=") || (c == "!") || (c == "<") || (c == ">")
                        || (c == "&") || (c == "|");

  // single-character tokens decided at once
  always_comb begin
    case (c)
      "+":     single_kind = cst_pkg::K_PLUS;
      "-":     single_kind = cst_pkg::K_MINUS;
      "*":     single_kind = cst_pkg::K_MUL;
      "%":     single_kind = cst_pkg::K_MOD;
      "(":     single_kind = cst_pkg::K_LPAREN;
      ")":     single_kind = cst_pkg::K_RPAREN;
      "{":     single_kind = cst_pkg::K_LBRACE;
      "}":     single_kind = cst_pkg::K_RBRACE;
      ";":     single_kind = cst_pkg::K_SEMI;
      ",":     single_kind = cst_pkg::K_COMMA;
      "0":     single_kind = cst_pkg::K_CONST;
      default: single_kind = cst_pkg::K_UNKNOWN;
    endcase
  end

  // held operator on its own; a lone & or | is unknown
  always_comb begin
    case (held_q)
      "=":     held_kind = cst_pkg::K_ASSIGN;
      "!":     held_kind = cst_pkg::K_NOT;
      "<":     held_kind = cst_pkg::K_LT;
      ">":     held_kind = cst_pkg::K_GT;
      default: held_kind = cst_pkg::K_UNKNOWN;
    endcase
  end

  // two-character operators
  always_comb begin
    pair_hit  = 1'b0;
    pair_kind = cst_pkg::K_EQ;
    if (c == "=") begin
      pair_hit = 1'b1;
      case (held_q)
        "=":     pair_kind = cst_pkg::K_EQ;
        "!":     pair_kind = cst_pkg::K_NE;
        "<":     pair_kind = cst_pkg::K_LE;
        ">":     pair_kind = cst_pkg::K_GE;
        default: pair_hit  = 1'b0;
      endcase
    end else if ((c == "&") && (held_q == "&")) begin
      pair_hit  = 1'b1;
      pair_kind = cst_pkg::K_AND;
    end else if ((c == "|") && (held_q == "|")) begin
      pair_hit  = 1'b1;
      pair_kind = cst_pkg::K_OR;
    end
  end

  // keyword filter: continue the word, or start one from the full set
  assign kw_cand_in = (mode_q == cst_pkg::M_IDENT) ? cand_q : 8'hff;
  assign kw_index   = (mode_q == cst_pkg::M_IDENT) ? plen_q : '0;

  cst_keyword_match #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_kw (
    .cand_i      (kw_cand_in),
    .index_i     (kw_index),
    .char_i      (c),
    .final_cand_i(cand_q),
    .final_len_i (plen_q),
    .cand_o      (kw_cand_out),
    .kind_o      (word_kind)
  );

  // does the current mode swallow this byte
  always_comb begin
    case (mode_q)
      cst_pkg::M_IDENT:      cont = is_alnum;
      cst_pkg::M_NUMBER:     cont = is_digit;
      cst_pkg::M_HELD:       cont = pair_hit;
      cst_pkg::M_SLASH:      cont = (c == "/") || (c == "*");
      cst_pkg::M_LINE:       cont = 1'b1;
      cst_pkg::M_BLOCK:      cont = 1'b1;
      cst_pkg::M_BLOCK_STAR: cont = 1'b1;
      default:               cont = 1'b0;
    endcase
  end

  assign pend  = (mode_q == cst_pkg::M_IDENT) || (mode_q == cst_pkg::M_NUMBER)
                 || (mode_q == cst_pkg::M_HELD) || (mode_q == cst_pkg::M_SLASH);
  assign again = !eot && !cont;

  // --------------------------------------------------------------- next state
  always_comb begin
    mode_d  = mode_q;
    held_d  = held_q;
    cand_d  = cand_q;
    pline_d = pline_q;
    poff_d  = poff_q;
    plen_d  = plen_q;
    pos_d   = (pos_q == '1) ? pos_q : pos_q + POSITION_BITS'(1);
    line_d  = line_q;
    if ((c == 8'h0a) && (line_q != '1)) begin
      line_d = line_q + LINE_BITS'(1);
    end

    case (mode_q)
      cst_pkg::M_IDENT: begin
        if (cont) begin
          cand_d = kw_cand_out;
          plen_d = (plen_q == '1) ? plen_q : plen_q + LENGTH_BITS'(1);
        end else begin
          mode_d = cst_pkg::M_IDLE;
        end
      end
      cst_pkg::M_NUMBER: begin
        if (cont) begin
          plen_d = (plen_q == '1) ? plen_q : plen_q + LENGTH_BITS'(1);
        end else begin
          mode_d = cst_pkg::M_IDLE;
        end
      end
      cst_pkg::M_SLASH: begin
        if (c == "/") begin
          mode_d = cst_pkg::M_LINE;
        end else if (c == "*") begin
          mode_d = cst_pkg::M_BLOCK;
        end else begin
          mode_d = cst_pkg::M_IDLE;
        end
      end
      cst_pkg::M_LINE: begin
        if (c == 8'h0a) begin
          mode_d = cst_pkg::M_IDLE;
        end
      end
      cst_pkg::M_BLOCK: begin
        if (c == "*") begin
          mode_d = cst_pkg::M_BLOCK_STAR;
        end
      end
      cst_pkg::M_BLOCK_STAR: begin
        if (c == "/") begin
          mode_d = cst_pkg::M_IDLE;
        end else if (c != "*") begin
          mode_d = cst_pkg::M_BLOCK;
        end
      end
      default: begin
        mode_d = cst_pkg::M_IDLE;
      end
    endcase

    // byte not swallowed: scan it from idle
    if (again && !is_ws) begin
      if ((is_digit && (c != "0")) || is_alpha || (c == "/") || is_held_char) begin
        pline_d = line_q;
        poff_d  = pos_q;
        plen_d  = LENGTH_BITS'(1);
        if (is_digit) begin
          mode_d = cst_pkg::M_NUMBER;
        end else if (is_alpha) begin
          mode_d = cst_pkg::M_IDENT;
          cand_d = kw_cand_out;
        end else if (c == "/") begin
          mode_d = cst_pkg::M_SLASH;
        end else begin
          mode_d = cst_pkg::M_HELD;
          held_d = c;
        end
      end
    end

    // end of text restarts the scan
    if (eot) begin
      mode_d  = cst_pkg::M_IDLE;
      held_d  = 8'd0;
      cand_d  = 8'd0;
      line_d  = LINE_BITS'(1);
      pos_d   = '0;
      poff_d  = '0;
      pline_d = LINE_BITS'(1);
      plen_d  = '0;
    end
  end

  // ------------------------------------------------------------------ tokens
  // token a: the pending token flushed by this byte
  // token b: a token started and finished by this byte, a pair, or end-of-file
  always_comb begin
    a_v    = pend && (eot || !cont);
    b_v    = 1'b0;
    b_kind = single_kind;
    case (mode_q)
      cst_pkg::M_IDENT:  a_kind = word_kind;
      cst_pkg::M_NUMBER: a_kind = cst_pkg::K_CONST;
      cst_pkg::M_HELD:   a_kind = held_kind;
      default:           a_kind = cst_pkg::K_DIV;
    endcase

    tok_a.token_kind   = a_kind;
    tok_a.token_number = tokno_q;
    tok_a.start_line   = pline_ext[15:0];
    tok_a.start_offset = poff_ext[23:0];
    tok_a.token_length = ((mode_q == cst_pkg::M_IDENT) || (mode_q == cst_pkg::M_NUMBER))
                         ? plen_ext[15:0] : 16'd1;
    tok_a.last_of_run  = 1'b0;

    tok_b.token_number = a_v ? tokno_inc1 : tokno_q;
    tok_b.start_line   = line_ext[15:0];
    tok_b.start_offset = pos_ext[23:0];
    tok_b.token_length = 16'd1;
    tok_b.last_of_run  = 1'b1;

    if (eot) begin
      b_v                = 1'b1;
      b_kind             = cst_pkg::K_EOF;
      tok_b.token_length = 16'd0;
    end else if ((mode_q == cst_pkg::M_HELD) && pair_hit) begin
      b_v                = 1'b1;
      b_kind             = pair_kind;
      tok_b.start_line   = pline_ext[15:0];
      tok_b.start_offset = poff_ext[23:0];
      tok_b.token_length = 16'd2;
    end else if (again && !is_ws && !(is_digit && (c != "0")) && !is_alpha
                 && (c != "/") && !is_held_char) begin
      b_v = 1'b1;
    end
    tok_b.token_kind  = b_kind;
    tok_a.last_of_run = !b_v;
  end

  // token index, saturating
  assign tokno_inc1 = (tokno_q == '1) ? tokno_q : tokno_q + 24'd1;
  assign tokno_inc2 = (tokno_inc1 == '1) ? tokno_inc1 : tokno_inc1 + 24'd1;

  always_comb begin
    if (eot) begin
      tokno_d = 24'd0;
    end else if (a_v && b_v) begin
      tokno_d = tokno_inc2;
    end else if (a_v || b_v) begin
      tokno_d = tokno_inc1;
    end else begin
      tokno_d = tokno_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= cst_pkg::M_IDLE;
      held_q  <= 8'd0;
      cand_q  <= 8'd0;
      line_q  <= LINE_BITS'(1);
      tokno_q <= 24'd0;
      pos_q   <= '0;
      poff_q  <= '0;
      pline_q <= LINE_BITS'(1);
      plen_q  <= '0;
    end else if (fire) begin
      mode_q  <= mode_d;
      held_q  <= held_d;
      cand_q  <= cand_d;
      line_q  <= line_d;
      tokno_q <= tokno_d;
      pos_q   <= pos_d;
      poff_q  <= poff_d;
      pline_q <= pline_d;
      plen_q  <= plen_d;
    end
  end

  // ------------------------------------------------------------- result queue
  cst_out_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_a_i   (fire && a_v),
    .data_a_i   (tok_a),
    .push_b_i   (fire && b_v),
    .data_b_i   (tok_b),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .count_o    (queue_count)
  );

`ifndef SYNTH
  // queue never overflows its four entries
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    queue_count <= 3'd4)
    else $error("result queue overflow");

  // end of text always produces an end-of-file token and restarts the scan
  a_eot_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && eot) |=> (mode_q == cst_pkg::M_IDLE) && (tokno_q == 24'd0)
                      && (pos_q == '0))
    else $error("scanner not restarted after end of text");

  // an end-of-text transaction emits an end-of-file token marked as the last of its run
  a_eot_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && eot) |-> b_v && (tok_b.token_kind == cst_pkg::K_EOF) && tok_b.last_of_run)
    else $error("end-of-file token missing");

  // a byte held in the input register is processed once there is room
  a_input_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && room) |=> !in_valid_q || $past(in_take))
    else $error("input register not drained");
`endif

endmodule

`default_nettype wire

### verif/c_subset_token_scanner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_subset_token_scanner_tb: self-checking bench for the token scanner
// Walks a directed byte table, then random C-like text with broken fragments
// and noise, through the valid/stall channels. Every token is compared field
// by field with an in-bench scanner model or a typed-in directed table token.
// ----------------------------------------------------------------------------

module c_subset_token_scanner_tb;

  localparam int unsigned CYCLE_LIMIT  = 100_000;
  localparam int unsigned RANDOM_BYTES = 1500;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned TAIL_CYCLES  = 20;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_VT  = 8'h0b;
  localparam logic [7:0] CH_FF  = 8'h0c;
  localparam logic [7:0] CH_CR  = 8'h0d;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  cst_pkg::in_item_t   in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  cst_pkg::out_token_t out_data_o;

  c_subset_token_scanner dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // scanner model
  // --------------------------------------------------------------------------

  string kw_spell [8] = '{"int", "void", "if", "else", "while", "break", "continue", "return"};
  string op_spell [23] = '{"+", "-", "*", "/", "%", "=", "==", "!=", "<", "<=", ">", ">=",
                           "&&", "||", "!", "(", ")", "{", "}", ";", ",", "&", "|"};
  logic [7:0] blank_codes [6] = '{" ", CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};

  cst_pkg::scan_mode_e sc_mode;
  logic [7:0]  sc_held;
  logic [7:0]  sc_cands;       // keywords still matching the open identifier
  logic [15:0] sc_line;
  logic [23:0] sc_token_no;
  logic [23:0] sc_pos;
  logic [23:0] sc_start_off;
  logic [15:0] sc_start_line;
  logic [15:0] sc_len;

  cst_pkg::out_token_t step_tokens [$];    // tokens caused by the byte just taken
  cst_pkg::out_token_t token_backlog [$];  // tokens owed by the scanner, oldest first
  int unsigned mismatches = 0;

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  // space, tab, lf, vt, ff, cr
  function automatic bit is_blank(logic [7:0] c);
    return c == " " || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic void reset_scanner();
    sc_mode       = cst_pkg::M_IDLE;
    sc_held       = '0;
    sc_cands      = '0;
    sc_line       = 16'd1;
    sc_token_no   = '0;
    sc_pos        = '0;
    sc_start_off  = '0;
    sc_start_line = 16'd1;
    sc_len        = '0;
  endfunction

  function automatic void add_token(cst_pkg::token_kind_e kind, logic [15:0] line,
                                    logic [23:0] offset, logic [15:0] len);
    cst_pkg::out_token_t t;
    if (step_tokens.size() >= 2) return;
    t.token_kind   = kind;
    t.token_number = sc_token_no;
    t.start_line   = line;
    t.start_offset = offset;
    t.token_length = len;
    t.last_of_run  = 1'b0;
    step_tokens.insert(step_tokens.size(), t);
    if (sc_token_no != '1) sc_token_no++;
  endfunction

  function automatic logic [7:0] narrow_keywords(logic [7:0] cands, logic [15:0] idx,
                                                 logic [7:0] c);
    logic [7:0] keep;
    keep = '0;
    for (int i = 0; i < 8; i++) begin
      if (cands[i] && idx < kw_spell[i].len() && kw_spell[i][idx] == c) keep[i] = 1'b1;
    end
    return keep;
  endfunction

  function automatic void flush_token();
    cst_pkg::token_kind_e kind;
    case (sc_mode)
      cst_pkg::M_IDENT: begin
        kind = cst_pkg::K_IDENT;
        for (int i = 0; i < 8; i++) begin
          if (sc_cands[i] && sc_len == kw_spell[i].len()) kind = cst_pkg::token_kind_e'(i);
        end
        add_token(kind, sc_start_line, sc_start_off, sc_len);
      end
      cst_pkg::M_NUMBER: add_token(cst_pkg::K_CONST, sc_start_line, sc_start_off, sc_len);
      cst_pkg::M_HELD: begin
        case (sc_held)
          "=":     kind = cst_pkg::K_ASSIGN;
          "!":     kind = cst_pkg::K_NOT;
          "<":     kind = cst_pkg::K_LT;
          ">":     kind = cst_pkg::K_GT;
          default: kind = cst_pkg::K_UNKNOWN;  // lone & or |
        endcase
        add_token(kind, sc_start_line, sc_start_off, 16'd1);
      end
      cst_pkg::M_SLASH: add_token(cst_pkg::K_DIV, sc_start_line, sc_start_off, 16'd1);
      default: ;
    endcase
    sc_mode = cst_pkg::M_IDLE;
  endfunction

  function automatic void start_pending(cst_pkg::scan_mode_e mode, logic [23:0] pos,
                                        logic [15:0] ln);
    sc_mode       = mode;
    sc_start_off  = pos;
    sc_start_line = ln;
    sc_len        = 16'd1;
  endfunction

  function automatic void idle_byte(logic [7:0] c, logic [23:0] pos, logic [15:0] ln);
    cst_pkg::token_kind_e kind;
    if (is_blank(c)) return;
    if (is_digit(c)) begin
      // a leading zero is a whole constant by itself
      if (c == "0") add_token(cst_pkg::K_CONST, ln, pos, 16'd1);
      else start_pending(cst_pkg::M_NUMBER, pos, ln);
    end else if (is_alpha(c)) begin
      start_pending(cst_pkg::M_IDENT, pos, ln);
      sc_cands = narrow_keywords(8'hff, 16'd0, c);
    end else if (c == "/") begin
      start_pending(cst_pkg::M_SLASH, pos, ln);
    end else if (c == "=" || c == "!" || c == "<" || c == ">" || c == "&" || c == "|") begin
      start_pending(cst_pkg::M_HELD, pos, ln);
      sc_held = c;
    end else begin
      case (c)
        "+":     kind = cst_pkg::K_PLUS;
        "-":     kind = cst_pkg::K_MINUS;
        "*":     kind = cst_pkg::K_MUL;
        "%":     kind = cst_pkg::K_MOD;
        "(":     kind = cst_pkg::K_LPAREN;
        ")":     kind = cst_pkg::K_RPAREN;
        "{":     kind = cst_pkg::K_LBRACE;
        "}":     kind = cst_pkg::K_RBRACE;
        ";":     kind = cst_pkg::K_SEMI;
        ",":     kind = cst_pkg::K_COMMA;
        default: kind = cst_pkg::K_UNKNOWN;
      endcase
      add_token(kind, ln, pos, 16'd1);
    end
  endfunction

  // advance the model by one taken byte, leaving its tokens in step_tokens
  function automatic void scan_byte(cst_pkg::in_item_t item);
    logic [7:0]  c;
    logic [23:0] pos;
    logic [15:0] ln;
    bit          again;
    bit          pair;
    cst_pkg::token_kind_e kind;
    c     = item.char_code;
    pos   = sc_pos;
    ln    = sc_line;
    again = 1'b1;
    pair  = 1'b0;
    kind  = cst_pkg::K_UNKNOWN;
    step_tokens.delete();
    if (item.end_of_text) begin
      flush_token();
      add_token(cst_pkg::K_EOF, ln, pos, 16'd0);
      reset_scanner();
    end else begin
      case (sc_mode)
        cst_pkg::M_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            sc_cands = narrow_keywords(sc_cands, sc_len, c);
            if (sc_len != '1) sc_len++;
            again = 1'b0;
          end else begin
            flush_token();
          end
        end
        cst_pkg::M_NUMBER: begin
          if (is_digit(c)) begin
            if (sc_len != '1) sc_len++;
            again = 1'b0;
          end else begin
            flush_token();
          end
        end
        cst_pkg::M_HELD: begin
          if (c == "=") begin
            pair = 1'b1;
            case (sc_held)
              "=":     kind = cst_pkg::K_EQ;
              "!":     kind = cst_pkg::K_NE;
              "<":     kind = cst_pkg::K_LE;
              ">":     kind = cst_pkg::K_GE;
              default: pair = 1'b0;
            endcase
          end else if (c == "&" && sc_held == "&") begin
            pair = 1'b1;
            kind = cst_pkg::K_AND;
          end else if (c == "|" && sc_held == "|") begin
            pair = 1'b1;
            kind = cst_pkg::K_OR;
          end
          if (pair) begin
            add_token(kind, sc_start_line, sc_start_off, 16'd2);
            sc_mode = cst_pkg::M_IDLE;
            again   = 1'b0;
          end else begin
            flush_token();
          end
        end
        cst_pkg::M_SLASH: begin
          if (c == "/") begin
            sc_mode = cst_pkg::M_LINE;
            again   = 1'b0;
          end else if (c == "*") begin
            sc_mode = cst_pkg::M_BLOCK;
            again   = 1'b0;
          end else begin
            flush_token();
          end
        end
        cst_pkg::M_LINE: begin
          if (c == CH_LF) sc_mode = cst_pkg::M_IDLE;
          again = 1'b0;
        end
        cst_pkg::M_BLOCK: begin
          if (c == "*") sc_mode = cst_pkg::M_BLOCK_STAR;
          again = 1'b0;
        end
        cst_pkg::M_BLOCK_STAR: begin
          if (c == "/") sc_mode = cst_pkg::M_IDLE;
          else if (c != "*") sc_mode = cst_pkg::M_BLOCK;
          again = 1'b0;
        end
        default: sc_mode = cst_pkg::M_IDLE;
      endcase
      if (again) idle_byte(c, pos, ln);
      if (sc_pos != '1) sc_pos++;
      if (c == CH_LF && sc_line != '1) sc_line++;
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // output side: stall pattern and token checking
  // --------------------------------------------------------------------------

  bit          hold_request = 1'b0;  // ask the receiver for one long hold-off
  bit          hold_done    = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned rx_style     = 0;
  int unsigned rx_left      = 0;
  int unsigned rx_tick      = 0;

  function automatic void check_token(cst_pkg::out_token_t got);
    cst_pkg::out_token_t want;
    if (token_backlog.size() == 0) begin
      $error("token %0d at offset %0d with nothing predicted", got.token_number,
             got.start_offset);
      mismatches++;
      return;
    end
    want = token_backlog.pop_front();
    if (got.token_kind !== want.token_kind) begin
      $error("token_kind: expected %0d, got %0d", want.token_kind, got.token_kind);
      mismatches++;
    end
    if (got.token_number !== want.token_number) begin
      $error("token_number: expected %0d, got %0d", want.token_number, got.token_number);
      mismatches++;
    end
    if (got.start_line !== want.start_line) begin
      $error("start_line: expected %0d, got %0d", want.start_line, got.start_line);
      mismatches++;
    end
    if (got.start_offset !== want.start_offset) begin
      $error("start_offset: expected %0d, got %0d", want.start_offset, got.start_offset);
      mismatches++;
    end
    if (got.token_length !== want.token_length) begin
      $error("token_length: expected %0d, got %0d", want.token_length, got.token_length);
      mismatches++;
    end
    if (got.last_of_run !== want.last_of_run) begin
      $error("last_of_run: expected %0d, got %0d", want.last_of_run, got.last_of_run);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) check_token(out_data_o);
      rx_tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_request && !hold_done) begin
        // long hold-off so the result queue fills and the input stalls
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else begin
        if (rx_left == 0) begin
          rx_style = $urandom_range(0, 3);
          rx_left  = $urandom_range(8, 80);
        end
        rx_left--;
        case (rx_style)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= 1'($urandom_range(0, 1));
          2:       out_stall_i <= (rx_tick % 3) == 0;
          default: out_stall_i <= $urandom_range(0, 7) == 0;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // run limit
  // --------------------------------------------------------------------------

  int unsigned cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------

  int unsigned burst_left  = 0;
  int unsigned bytes_taken = 0;

  // offer one transaction and hold it until taken; the predicted tokens are
  // queued, or the typed-in token where the directed table gives one
  task automatic send_byte(input cst_pkg::in_item_t item, input bit use_fixed,
                           input cst_pkg::out_token_t fixed_tok);
    int unsigned       pause;
    cst_pkg::in_item_t junk;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      pause      = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (pause > 0) begin
        junk.char_code   = 8'($urandom);
        junk.end_of_text = 1'($urandom);
        in_valid_i <= 1'b0;
        in_data_i  <= junk;
        repeat (pause) @(posedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    bytes_taken++;
    scan_byte(item);
    if (use_fixed) token_backlog.insert(token_backlog.size(), fixed_tok);
    else foreach (step_tokens[i]) token_backlog.insert(token_backlog.size(), step_tokens[i]);
  endtask

  task automatic send_char(input logic [7:0] c);
    send_byte(cst_pkg::in_item_t'{char_code: c, end_of_text: 1'b0}, 1'b0, '0);
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_char(s[k]);
  endtask

  function automatic logic [7:0] word_char(bit first);
    int unsigned r;
    r = $urandom_range(0, first ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return "_";
    return 8'("0" + r - 53);
  endfunction

  // one random piece of source text, mostly well formed
  task automatic send_fragment();
    int unsigned pick;
    int unsigned n;
    string       word;
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      send_byte(cst_pkg::in_item_t'{char_code: 8'($urandom_range(0, 255)),
                                    end_of_text: 1'b1}, 1'b0, '0);
    end else if (pick < 20) begin
      // keyword, keyword prefix or keyword with a tail
      word = kw_spell[$urandom_range(0, 7)];
      case ($urandom_range(0, 3))
        0:       send_text(word.substr(0, word.len() - 2));
        1: begin
          send_text(word);
          send_char(word_char(1'b0));
        end
        default: send_text(word);
      endcase
    end else if (pick < 32) begin
      n = $urandom_range(1, 8);
      for (int k = 0; k < n; k++) send_char(word_char(k == 0));
    end else if (pick < 42) begin
      n = $urandom_range(1, 5);
      repeat (n) send_char(8'("0" + $urandom_range(0, 9)));
    end else if (pick < 66) begin
      send_text(op_spell[$urandom_range(0, 22)]);
    end else if (pick < 78) begin
      send_char(blank_codes[$urandom_range(0, 5)]);
    end else if (pick < 84) begin
      send_text("//");
      repeat ($urandom_range(0, 8)) send_char(8'($urandom_range(0, 255)));
      send_char(CH_LF);
    end else if (pick < 91) begin
      send_text("/*");
      // "/*/" must stay open
      if ($urandom_range(0, 3) == 0) send_char("/");
      n = $urandom_range(0, 8);
      repeat (n) begin
        case ($urandom_range(0, 4))
          0:       send_char("*");
          1:       send_char("/");
          2:       send_char(8'($urandom_range(0, 255)));
          default: send_char(word_char(1'b0));
        endcase
      end
      if ($urandom_range(0, 7) != 0) send_text("*/");
    end else begin
      send_char(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 1) == 0) send_char(blank_codes[$urandom_range(0, 5)]);
  endtask

  // --------------------------------------------------------------------------
  // directed table: fixed rows carry the token typed in, others use the model
  // --------------------------------------------------------------------------

  typedef struct {
    logic [7:0]           ch;
    logic                 eot;
    bit                   known;
    cst_pkg::token_kind_e kind;
    int unsigned          number;
    int unsigned          line;
    int unsigned          offset;
    int unsigned          len;
  } intro_row_t;

  intro_row_t intro_rows [28] = '{
    '{"0",   1'b0, 1'b1, cst_pkg::K_CONST,   0, 1,  0, 1},  // leading zero right after reset
    '{"i",   1'b0, 1'b0, cst_pkg::K_IDENT,   0, 0,  0, 0},
    '{"f",   1'b0, 1'b0, cst_pkg::K_IDENT,   0, 0,  0, 0},
    '{" ",   1'b0, 1'b1, cst_pkg::K_IF,      1, 1,  1, 2},  // keyword closed by a blank
    '{"&",   1'b0, 1'b0, cst_pkg::K_IDENT,   0, 0,  0, 0},
    '{"&",   1'b0, 1'b1, cst_pkg::K_AND,     2, 1,  4, 2},
    '{"|",   1'b0, 1'b0, cst_pkg::K_IDENT,   0, 0,  0, 0},
    '{"=",   1'b0, 1'b1, cst_pkg::K_UNKNOWN, 3, 1,  6, 1},  // lone bar
    '{"=",   1'b0, 1'b0, cst_pkg::K_IDENT,   0, 0,  0, 0},
    '{"/",   1'b0, 1'b0, cst_pkg::K_IDENT,   0, 0,  0, 0},
    '{"*",   1'b0, 1'b0, cst_pkg::K_IDENT,   0, 0,  0, 0},
    '{"/",   1'b0, 1'b0, cst_pkg::K_IDENT,   0, 0,  0, 0},  // slash right after opener
    '{"*",   1'b0, 1'b0, cst_pkg::K_IDENT,   0, 0,  0, 0},
    '{"/",   1'b0, 1'b0, cst_pkg::K_IDENT,   0, 0,  0, 0},
    '{8'hff, 1'b0, 1'b1, cst_pkg::K_UNKNOWN, 5, 1, 14, 1},  // top byte
    '{8'h00, 1'b0, 1'b1, cst_pkg::K_UNKNOWN, 6, 1, 15, 1},  // nul byte
    '{CH_LF, 1'b0, 1'b0, cst_pkg::K_IDENT,   0, 0,  0, 0},
    '{"/",   1'b0, 1'b0, cst_pkg::K_IDENT,   0, 0,  0, 0},
    '{"/",   1'b0, 1'b0, cst_pkg::K_IDENT,   0, 0,  0, 0},
    '{"x",   1'b0, 1'b0, cst_pkg::K_IDENT,   0, 0,  0, 0},
    '{CH_LF, 1'b0, 1'b0, cst_pkg::K_IDENT,   0, 0,  0, 0},
    '{"5",   1'b0, 1'b0, cst_pkg::K_IDENT,   0, 0,  0, 0},
    '{"!",   1'b0, 1'b0, cst_pkg::K_IDENT,   0, 0,  0, 0},
    '{"<",   1'b0, 1'b0, cst_pkg::K_IDENT,   0, 0,  0, 0},
    '{8'ha5, 1'b1, 1'b0, cst_pkg::K_IDENT,   0, 0,  0, 0},  // flush plus end-of-file
    '{"/",   1'b0, 1'b0, cst_pkg::K_IDENT,   0, 0,  0, 0},
    '{"*",   1'b0, 1'b0, cst_pkg::K_IDENT,   0, 0,  0, 0},
    '{8'h00, 1'b1, 1'b1, cst_pkg::K_EOF,     0, 1,  2, 0}   // open comment dropped at the end
  };

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------

  initial begin
    cst_pkg::out_token_t row_tok;
    int unsigned         random_start;
    reset_scanner();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (intro_rows[r]) begin
      row_tok.token_kind   = intro_rows[r].kind;
      row_tok.token_number = 24'(intro_rows[r].number);
      row_tok.start_line   = 16'(intro_rows[r].line);
      row_tok.start_offset = 24'(intro_rows[r].offset);
      row_tok.token_length = 16'(intro_rows[r].len);
      row_tok.last_of_run  = 1'b1;
      send_byte(cst_pkg::in_item_t'{char_code: intro_rows[r].ch,
                                    end_of_text: intro_rows[r].eot},
                intro_rows[r].known, row_tok);
    end

    // random text; the receiver's long hold-off lands early in it
    random_start = bytes_taken;
    while (bytes_taken - random_start < RANDOM_BYTES) begin
      if (bytes_taken - random_start > 200) hold_request = 1'b1;
      send_fragment();
    end
    send_byte(cst_pkg::in_item_t'{char_code: 8'h00, end_of_text: 1'b1}, 1'b0, '0);
    in_valid_i <= 1'b0;

    while (token_backlog.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
